[rtl/tcru_pkg.sv]
// shared types, constants, micro-program and float compare helpers
`default_nettype none
package tcru_pkg;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} fop_t;

  // second operand source
  typedef enum logic [1:0] {BSRC_RAM, BSRC_THREE, BSRC_TWO} bsrc_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_READ, S_START, S_WAIT, S_ZERO, S_OUT
  } seq_state_t;

  // arithmetic unit states
  typedef enum logic [2:0] {
    F_IDLE, F_SETUP, F_DPRE, F_DIV, F_NORM, F_ROUND, F_DONE
  } fpu_state_t;

  typedef struct packed {
    fop_t       op;
    logic [4:0] a;
    logic [4:0] b;
    bsrc_t      bsrc;
    logic [4:0] dst;
  } uop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

  localparam int RAM_DEPTH = 32;
  localparam int RAM_AW    = 5;

  // configuration register indexes
  localparam logic CFG_LAMBDA = 1'b0;
  localparam logic CFG_ITER   = 1'b1;

  // float constants
  localparam logic [31:0] F_THREE = 32'h4040_0000;
  localparam logic [31:0] F_TWO   = 32'h4000_0000;
  localparam logic [31:0] F_QNAN  = 32'hFFC0_0000;
  localparam logic [31:0] F_QBIT  = 32'h0040_0000;

  // scratch slots
  localparam logic [4:0] SLOT_BASE = 5'd0;
  localparam logic [4:0] SLOT_CORR = 5'd1;
  localparam logic [4:0] SLOT_LIN  = 5'd2;
  localparam logic [4:0] SLOT_OLD  = 5'd3;
  localparam logic [4:0] SLOT_T0   = 5'd4;
  localparam logic [4:0] SLOT_P    = 5'd5;
  localparam logic [4:0] SLOT_Q    = 5'd6;
  localparam logic [4:0] SLOT_X    = 5'd7;
  localparam logic [4:0] SLOT_T1   = 5'd8;
  localparam logic [4:0] SLOT_U    = 5'd9;
  localparam logic [4:0] SLOT_D    = 5'd10;
  localparam logic [4:0] SLOT_DSQ  = 5'd11;
  localparam logic [4:0] SLOT_V    = 5'd12;
  localparam logic [4:0] SLOT_W    = 5'd13;
  localparam logic [4:0] SLOT_W2   = 5'd14;
  localparam logic [4:0] SLOT_F    = 5'd15;
  localparam logic [4:0] SLOT_H    = 5'd16;
  localparam logic [4:0] SLOT_E1   = 5'd17;
  localparam logic [4:0] SLOT_NUM  = 5'd18;
  localparam logic [4:0] SLOT_H2   = 5'd19;
  localparam logic [4:0] SLOT_E2   = 5'd20;
  localparam logic [4:0] SLOT_G1   = 5'd21;
  localparam logic [4:0] SLOT_FF   = 5'd22;
  localparam logic [4:0] SLOT_DEN  = 5'd23;
  localparam logic [4:0] SLOT_R    = 5'd24;
  localparam logic [4:0] SLOT_DIF  = 5'd25;
  localparam logic [4:0] SLOT_DIF2 = 5'd26;

  // program counter landmarks
  localparam logic [4:0] PC_PRE_LAST   = 5'd2;
  localparam logic [4:0] PC_LOOP_FIRST = 5'd3;
  localparam logic [4:0] PC_LOOP_LAST  = 5'd20;
  localparam logic [4:0] PC_POST_FIRST = 5'd21;
  localparam logic [4:0] PC_POST_LAST  = 5'd22;

  function automatic uop_t uprog(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = uop_t'{FOP_SUB, SLOT_BASE, SLOT_CORR, BSRC_RAM, SLOT_T0};
      5'd1:    u = uop_t'{FOP_DIV, SLOT_LIN, SLOT_T0, BSRC_RAM, SLOT_P};
      5'd2:    u = uop_t'{FOP_DIV, SLOT_OLD, SLOT_T0, BSRC_RAM, SLOT_Q};
      5'd3:    u = uop_t'{FOP_MUL, SLOT_X, SLOT_X, BSRC_THREE, SLOT_T1};
      5'd4:    u = uop_t'{FOP_MUL, SLOT_T1, SLOT_X, BSRC_RAM, SLOT_U};
      5'd5:    u = uop_t'{FOP_ADD, SLOT_U, SLOT_P, BSRC_RAM, SLOT_D};
      5'd6:    u = uop_t'{FOP_MUL, SLOT_D, SLOT_D, BSRC_RAM, SLOT_DSQ};
      5'd7:    u = uop_t'{FOP_MUL, SLOT_X, SLOT_X, BSRC_RAM, SLOT_V};
      5'd8:    u = uop_t'{FOP_ADD, SLOT_V, SLOT_P, BSRC_RAM, SLOT_W};
      5'd9:    u = uop_t'{FOP_MUL, SLOT_W, SLOT_X, BSRC_RAM, SLOT_W2};
      5'd10:   u = uop_t'{FOP_ADD, SLOT_W2, SLOT_Q, BSRC_RAM, SLOT_F};
      5'd11:   u = uop_t'{FOP_MUL, SLOT_F, SLOT_T1, BSRC_RAM, SLOT_H};
      5'd12:   u = uop_t'{FOP_SUB, SLOT_DSQ, SLOT_H, BSRC_RAM, SLOT_E1};
      5'd13:   u = uop_t'{FOP_MUL, SLOT_F, SLOT_E1, BSRC_RAM, SLOT_NUM};
      5'd14:   u = uop_t'{FOP_MUL, SLOT_H, SLOT_H, BSRC_TWO, SLOT_H2};
      5'd15:   u = uop_t'{FOP_SUB, SLOT_DSQ, SLOT_H2, BSRC_RAM, SLOT_E2};
      5'd16:   u = uop_t'{FOP_MUL, SLOT_D, SLOT_E2, BSRC_RAM, SLOT_G1};
      5'd17:   u = uop_t'{FOP_MUL, SLOT_F, SLOT_F, BSRC_RAM, SLOT_FF};
      5'd18:   u = uop_t'{FOP_ADD, SLOT_G1, SLOT_FF, BSRC_RAM, SLOT_DEN};
      5'd19:   u = uop_t'{FOP_DIV, SLOT_NUM, SLOT_DEN, BSRC_RAM, SLOT_R};
      5'd20:   u = uop_t'{FOP_SUB, SLOT_X, SLOT_R, BSRC_RAM, SLOT_X};
      5'd21:   u = uop_t'{FOP_SUB, SLOT_X, SLOT_OLD, BSRC_RAM, SLOT_DIF};
      5'd22:   u = uop_t'{FOP_MUL, SLOT_DIF, SLOT_DIF, BSRC_RAM, SLOT_DIF2};
      default: u = uop_t'{FOP_ADD, SLOT_X, SLOT_X, BSRC_RAM, SLOT_DIF2};
    endcase
    return u;
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // total order key for non-NaN values
  function automatic logic [31:0] fp_key(input logic [31:0] v);
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) r = 1'b0;
    else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b0;
    else r = fp_key(a) > fp_key(b);
    return r;
  endfunction

  function automatic logic fp_ge(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) r = 1'b0;
    else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b1;
    else r = fp_key(a) >= fp_key(b);
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/tcru_ram.sv]
// generic single-write, dual registered-read ram
`default_nettype none
module tcru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
`default_nettype wire

[rtl/tcru_fpu.sv]
// multi-cycle single-precision add, subtract, multiply and divide unit
`default_nettype none
module tcru_fpu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcru_pkg::fpu_req_t req,
  input  wire logic [31:0]        a,
  input  wire logic [31:0]        b,
  output tcru_pkg::fpu_rsp_t      rsp
);

  tcru_pkg::fpu_state_t state_r, state_nxt;
  tcru_pkg::fop_t       op_r, op_nxt;
  logic [31:0]        a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [49:0]        m_r, m_nxt;
  logic signed [11:0] ex_r, ex_nxt, ea_r, ea_nxt, eb_r, eb_nxt;
  logic               sign_r, sign_nxt, zs_r, zs_nxt, sub_r, sub_nxt;
  logic [23:0]        sa_r, sa_nxt, sb_r, sb_nxt;
  logic [24:0]        rem_r, rem_nxt;
  logic [25:0]        q_r, q_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  // setup stage decode
  logic [31:0]        bb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]         fa_eff, fb_eff;
  logic [23:0]        sig_a, sig_b;
  logic signed [11:0] e_a, e_b;
  logic               spec;
  logic [31:0]        spec_val;
  logic               sgn_md;
  // add path
  logic               swap;
  logic [31:0]        big, sml;
  logic [7:0]         fbig, fsml, dsh;
  logic [49:0]        big_ext, sml_ext, sml_sh;
  logic               sml_st;
  logic [47:0]        prod;
  // divide step
  logic               qbit;
  logic [24:0]        rem_sub;
  // normalise and round
  logic signed [11:0] lead_e, dn_sh;
  logic [5:0]         sh6;
  logic [49:0]        dn_mask;
  logic [23:0]        rsig;
  logic               rnd;
  logic [30:0]        rbase;

  always_comb begin
    bb     = (op_r == tcru_pkg::FOP_SUB) ? {~b_r[31], b_r[30:0]} : b_r;
    a_nan  = tcru_pkg::fp_is_nan(a_r);
    b_nan  = tcru_pkg::fp_is_nan(b_r);
    a_inf  = (a_r[30:0] == 31'h7F80_0000);
    b_inf  = (b_r[30:0] == 31'h7F80_0000);
    a_zero = (a_r[30:0] == 31'd0);
    b_zero = (b_r[30:0] == 31'd0);
    fa_eff = (a_r[30:23] == 8'd0) ? 8'd1 : a_r[30:23];
    fb_eff = (b_r[30:23] == 8'd0) ? 8'd1 : b_r[30:23];
    sig_a  = {a_r[30:23] != 8'd0, a_r[22:0]};
    sig_b  = {b_r[30:23] != 8'd0, b_r[22:0]};
    e_a    = $signed({4'd0, fa_eff}) - 12'sd127;
    e_b    = $signed({4'd0, fb_eff}) - 12'sd127;
    sgn_md = a_r[31] ^ b_r[31];

    spec     = 1'b1;
    spec_val = tcru_pkg::F_QNAN;
    if (a_nan) begin
      spec_val = a_r | tcru_pkg::F_QBIT;
    end else if (b_nan) begin
      spec_val = b_r | tcru_pkg::F_QBIT;
    end else begin
      case (op_r)
        tcru_pkg::FOP_ADD, tcru_pkg::FOP_SUB: begin
          if (a_inf && b_inf && (a_r[31] != bb[31])) spec_val = tcru_pkg::F_QNAN;
          else if (a_inf) spec_val = a_r;
          else if (b_inf) spec_val = bb;
          else spec = 1'b0;
        end
        tcru_pkg::FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = tcru_pkg::F_QNAN;
          else if (a_inf || b_inf) spec_val = {sgn_md, 31'h7F80_0000};
          else if (a_zero || b_zero) spec_val = {sgn_md, 31'd0};
          else spec = 1'b0;
        end
        tcru_pkg::FOP_DIV: begin
          if ((a_zero && b_zero) || (a_inf && b_inf)) spec_val = tcru_pkg::F_QNAN;
          else if (a_inf || b_zero) spec_val = {sgn_md, 31'h7F80_0000};
          else if (b_inf || a_zero) spec_val = {sgn_md, 31'd0};
          else spec = 1'b0;
        end
        default: spec = 1'b1;
      endcase
    end

    // alignment for add and subtract
    swap    = bb[30:0] > a_r[30:0];
    big     = swap ? bb : a_r;
    sml     = swap ? a_r : bb;
    fbig    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    fsml    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dsh     = fbig - fsml;
    big_ext = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
    sml_ext = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
    sml_sh  = sml_ext >> dsh;
    sml_st  = (sml_ext & ~({50{1'b1}} << dsh)) != 50'd0;

    prod = sig_a * sig_b;

    rem_sub = rem_r - {1'b0, sb_r};
    qbit    = rem_r >= {1'b0, sb_r};

    lead_e  = ex_r + 12'sd49;
    dn_sh   = -12'sd126 - lead_e;
    sh6     = (dn_sh > 12'sd50) ? 6'd50 : dn_sh[5:0];
    dn_mask = ~({50{1'b1}} << sh6);
    rsig    = m_r[49:26];
    rnd     = m_r[25] && ((m_r[24:0] != 25'd0) || rsig[0]);
    rbase   = sub_r ? {8'd0, rsig[22:0]} : {lead_e[7:0] + 8'd127, rsig[22:0]};
  end

  // datapath next values
  always_comb begin
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    res_nxt  = res_r;
    m_nxt    = m_r;
    ex_nxt   = ex_r;
    ea_nxt   = ea_r;
    eb_nxt   = eb_r;
    sign_nxt = sign_r;
    zs_nxt   = zs_r;
    sub_nxt  = sub_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      tcru_pkg::F_IDLE: begin
        if (req.start) begin
          op_nxt = req.op;
          a_nxt  = a;
          b_nxt  = b;
        end
      end
      tcru_pkg::F_SETUP: begin
        res_nxt = spec_val;
        sub_nxt = 1'b0;
        sa_nxt  = sig_a;
        sb_nxt  = sig_b;
        ea_nxt  = e_a;
        eb_nxt  = e_b;
        cnt_nxt = 5'd0;
        if (op_r == tcru_pkg::FOP_MUL || op_r == tcru_pkg::FOP_DIV) begin
          sign_nxt = sgn_md;
          m_nxt    = {prod, 2'b00};
          ex_nxt   = e_a + e_b - 12'sd48;
        end else begin
          sign_nxt = big[31];
          zs_nxt   = a_r[31] & bb[31];
          ex_nxt   = $signed({4'd0, fbig}) - 12'sd127 - 12'sd48;
          if (a_r[31] ^ bb[31]) m_nxt = big_ext - (sml_sh | {49'd0, sml_st});
          else m_nxt = big_ext + (sml_sh | {49'd0, sml_st});
        end
      end
      tcru_pkg::F_DPRE: begin
        if (!sa_r[23]) begin
          sa_nxt = {sa_r[22:0], 1'b0};
          ea_nxt = ea_r - 12'sd1;
        end else if (!sb_r[23]) begin
          sb_nxt = {sb_r[22:0], 1'b0};
          eb_nxt = eb_r - 12'sd1;
        end else begin
          rem_nxt = {1'b0, sa_r};
          q_nxt   = 26'd0;
        end
      end
      tcru_pkg::F_DIV: begin
        rem_nxt = {(qbit ? rem_sub[23:0] : rem_r[23:0]), 1'b0};
        q_nxt   = {q_r[24:0], qbit};
        cnt_nxt = cnt_r + 5'd1;
        m_nxt   = {q_r[24:0], qbit, 23'd0, (qbit ? rem_sub : rem_r) != 25'd0};
        ex_nxt  = ea_r - eb_r - 12'sd49;
      end
      tcru_pkg::F_NORM: begin
        if (m_r == 50'd0) begin
          res_nxt = {zs_r, 31'd0};
        end else if (!m_r[49]) begin
          if (m_r[49:42] == 8'd0) begin
            m_nxt  = {m_r[41:0], 8'd0};
            ex_nxt = ex_r - 12'sd8;
          end else begin
            m_nxt  = {m_r[48:0], 1'b0};
            ex_nxt = ex_r - 12'sd1;
          end
        end else if (lead_e < -12'sd126) begin
          // below the normal range: shift into subnormal position
          m_nxt   = (m_r >> sh6) | {49'd0, (m_r & dn_mask) != 50'd0};
          sub_nxt = 1'b1;
        end
      end
      tcru_pkg::F_ROUND: begin
        if (!sub_r && lead_e > 12'sd127) res_nxt = {sign_r, 31'h7F80_0000};
        else res_nxt = {sign_r, rbase + {30'd0, rnd}};
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcru_pkg::F_IDLE:  if (req.start) state_nxt = tcru_pkg::F_SETUP;
      tcru_pkg::F_SETUP: begin
        if (spec) state_nxt = tcru_pkg::F_DONE;
        else if (op_r == tcru_pkg::FOP_DIV) state_nxt = tcru_pkg::F_DPRE;
        else state_nxt = tcru_pkg::F_NORM;
      end
      tcru_pkg::F_DPRE:  if (sa_r[23] && sb_r[23]) state_nxt = tcru_pkg::F_DIV;
      tcru_pkg::F_DIV:   if (cnt_r == 5'd25) state_nxt = tcru_pkg::F_NORM;
      tcru_pkg::F_NORM: begin
        if (m_r == 50'd0) state_nxt = tcru_pkg::F_DONE;
        else if (m_r[49]) state_nxt = tcru_pkg::F_ROUND;
      end
      tcru_pkg::F_ROUND: state_nxt = tcru_pkg::F_DONE;
      tcru_pkg::F_DONE:  state_nxt = tcru_pkg::F_IDLE;
      default:           state_nxt = tcru_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == tcru_pkg::F_DONE);
    rsp.res  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcru_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    m_r    <= m_nxt;
    ex_r   <= ex_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    sign_r <= sign_nxt;
    zs_r   <= zs_nxt;
    sub_r  <= sub_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule
`default_nettype wire

[rtl/thresholded_cubic_root_update_unit.sv]
// thresholded cubic root update: sequencer around one shared float unit
//
// usage
//   in_*  : one element per transfer (base, correction, linear term, old
//           parameter as single-precision bits, tlast closes a block)
//   out_* : one result per element (new parameter, running maximum of the
//           squared change, tlast echoes the block end)
//   cfg_* : write-only registers, to be written while the unit is idle;
//           the block itself does not enforce this
// operation
//   one element at a time; in_tready is high only while idle.  each float
//   operation fetches its operands from the scratch ram, then runs in the
//   shared unit, longer after cancellation or with subnormals; a divide
//   uses a 26-step restoring divider.  an element runs loading, setup and
//   wrap-up plus each refinement step, ten by default; none below threshold
// reset
//   threshold 0, ten steps, running maximum +0, no result pending
// stall
//   a finished result sits in the output register; the unit takes the next
//   element meanwhile and holds its own result until the register drains
`default_nettype none
module thresholded_cubic_root_update_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // base_value, correction, linear_term, old_param (lowest bit up)
  input  wire logic [127:0] in_tdata,
  // item_last
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_param, max_sq_change (lowest bit up)
  output logic [63:0]       out_tdata,
  // block_done
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  tcru_pkg::seq_state_t state_r, state_nxt;
  logic [4:0]   pc_r, pc_nxt;
  logic [2:0]   ld_r, ld_nxt;
  logic [4:0]   iter_r, iter_nxt;
  logic [127:0] item_r, item_nxt;
  logic         last_r, last_nxt;
  logic [31:0]  lambda_r;
  logic [4:0]   steps_r;
  logic [31:0]  run_max_r, run_max_nxt;
  logic [31:0]  x_r, x_nxt;
  logic [31:0]  diff2_r, diff2_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  out_data_r, out_data_nxt;
  logic         out_last_r, out_last_nxt;

  tcru_pkg::uop_t     uop;
  tcru_pkg::fpu_req_t fpu_req;
  tcru_pkg::fpu_rsp_t fpu_rsp;
  logic        ram_we;
  logic [4:0]  ram_waddr;
  logic [31:0] ram_wdata, rd_a, rd_b, op_b;
  logic        out_free, keep;
  logic [4:0]  steps_eff;
  logic [31:0] neg_lambda, new_max;

  assign uop        = tcru_pkg::uprog(pc_r);
  assign out_free   = !out_valid_r || out_tready;
  assign steps_eff  = (steps_r == 5'd0) ? 5'd1 : steps_r;
  assign neg_lambda = {~lambda_r[31], lambda_r[30:0]};
  // threshold test on q, which is the result of the last setup operation
  assign keep       = tcru_pkg::fp_ge(fpu_rsp.res, lambda_r) ||
                      tcru_pkg::fp_ge(neg_lambda, fpu_rsp.res);
  assign new_max    = tcru_pkg::fp_gt(run_max_r, diff2_r) ? run_max_r : diff2_r;

  // constant operands come from the sequencer, not the scratch ram
  always_comb begin
    case (uop.bsrc)
      tcru_pkg::BSRC_THREE: op_b = tcru_pkg::F_THREE;
      tcru_pkg::BSRC_TWO:   op_b = tcru_pkg::F_TWO;
      default:              op_b = rd_b;
    endcase
  end

  tcru_ram #(
    .WIDTH (32),
    .DEPTH (tcru_pkg::RAM_DEPTH)
  ) u_scratch (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (uop.a),
    .raddr_b (uop.b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  tcru_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .a     (rd_a),
    .b     (op_b),
    .rsp   (fpu_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcru_pkg::S_IDLE:  if (in_tvalid) state_nxt = tcru_pkg::S_LOAD;
      tcru_pkg::S_LOAD:  if (ld_r == 3'd4) state_nxt = tcru_pkg::S_READ;
      tcru_pkg::S_READ:  state_nxt = tcru_pkg::S_START;
      tcru_pkg::S_START: state_nxt = tcru_pkg::S_WAIT;
      tcru_pkg::S_WAIT: begin
        if (fpu_rsp.done) begin
          if (pc_r == tcru_pkg::PC_POST_LAST) state_nxt = tcru_pkg::S_OUT;
          else if (pc_r == tcru_pkg::PC_PRE_LAST && !keep) state_nxt = tcru_pkg::S_ZERO;
          else state_nxt = tcru_pkg::S_READ;
        end
      end
      tcru_pkg::S_ZERO:  state_nxt = tcru_pkg::S_READ;
      tcru_pkg::S_OUT:   if (out_free) state_nxt = tcru_pkg::S_IDLE;
      default:           state_nxt = tcru_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready     = (state_r == tcru_pkg::S_IDLE);
    fpu_req.start = (state_r == tcru_pkg::S_START);
    fpu_req.op    = uop.op;
    ram_we        = 1'b0;
    ram_waddr     = uop.dst;
    ram_wdata     = fpu_rsp.res;
    pc_nxt        = pc_r;
    ld_nxt        = ld_r;
    iter_nxt      = iter_r;
    item_nxt      = item_r;
    last_nxt      = last_r;
    x_nxt         = x_r;
    diff2_nxt     = diff2_r;
    run_max_nxt   = run_max_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      tcru_pkg::S_IDLE: begin
        ld_nxt = 3'd0;
        pc_nxt = 5'd0;
        if (in_tvalid) begin
          item_nxt = in_tdata;
          last_nxt = in_tlast;
        end
      end
      tcru_pkg::S_LOAD: begin
        // old parameter goes in twice: as itself and as the start estimate
        ram_we = 1'b1;
        ld_nxt = ld_r + 3'd1;
        case (ld_r)
          3'd0:    begin ram_waddr = tcru_pkg::SLOT_BASE; ram_wdata = item_r[31:0];   end
          3'd1:    begin ram_waddr = tcru_pkg::SLOT_CORR; ram_wdata = item_r[63:32];  end
          3'd2:    begin ram_waddr = tcru_pkg::SLOT_LIN;  ram_wdata = item_r[95:64];  end
          3'd3:    begin ram_waddr = tcru_pkg::SLOT_OLD;  ram_wdata = item_r[127:96]; end
          default: begin ram_waddr = tcru_pkg::SLOT_X;    ram_wdata = item_r[127:96]; end
        endcase
      end
      tcru_pkg::S_WAIT: begin
        if (fpu_rsp.done) begin
          ram_we = 1'b1;
          if (pc_r == tcru_pkg::PC_PRE_LAST) begin
            pc_nxt   = tcru_pkg::PC_LOOP_FIRST;
            iter_nxt = 5'd0;
          end else if (pc_r == tcru_pkg::PC_LOOP_LAST) begin
            // one refinement step done
            x_nxt    = fpu_rsp.res;
            iter_nxt = iter_r + 5'd1;
            if (iter_r + 5'd1 < steps_eff) pc_nxt = tcru_pkg::PC_LOOP_FIRST;
            else pc_nxt = tcru_pkg::PC_POST_FIRST;
          end else if (pc_r == tcru_pkg::PC_POST_LAST) begin
            diff2_nxt = fpu_rsp.res;
          end else begin
            pc_nxt = pc_r + 5'd1;
          end
        end
      end
      tcru_pkg::S_ZERO: begin
        // below threshold: the new parameter is +0
        ram_we    = 1'b1;
        ram_waddr = tcru_pkg::SLOT_X;
        ram_wdata = 32'd0;
        x_nxt     = 32'd0;
        pc_nxt    = tcru_pkg::PC_POST_FIRST;
      end
      tcru_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {new_max, x_r};
          out_last_nxt  = last_r;
          run_max_nxt   = last_r ? 32'd0 : new_max;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcru_pkg::S_IDLE;
      pc_r        <= 5'd0;
      ld_r        <= 3'd0;
      iter_r      <= 5'd0;
      lambda_r    <= 32'd0;
      steps_r     <= 5'd10;
      run_max_r   <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ld_r        <= ld_nxt;
      iter_r      <= iter_nxt;
      run_max_r   <= run_max_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == tcru_pkg::CFG_LAMBDA) lambda_r <= cfg_wdata;
        else steps_r <= cfg_wdata[4:0];
      end
    end
    item_r     <= item_nxt;
    last_r     <= last_nxt;
    x_r        <= x_nxt;
    diff2_r    <= diff2_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // program counter stays inside the micro-program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= tcru_pkg::PC_POST_LAST)
    else $error("pc out of range");

  // the float unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_rsp.done |-> state_r == tcru_pkg::S_WAIT)
    else $error("float unit result outside wait");

  // a block end clears the running maximum
  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcru_pkg::S_OUT && out_free && last_r) |=> run_max_r == 32'd0)
    else $error("running maximum not cleared");

  // results are only produced once the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> out_valid_nxt)
    else $error("pending result dropped");

endmodule
`default_nettype wire
